[hdl/mcpg_pkg.sv]
// Shared types and constants for the midpoint circle pixel generator.
package mcpg_pkg;

  localparam int PIX_W    = 14;
  localparam int CHAN_W   = 8;
  localparam int COLOUR_W = 3 * CHAN_W;
  localparam int IN_W     = 12;
  localparam int OCT_W    = 3;
  localparam int Q_CNT_W  = 2;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } mcpg_op_t;

  typedef struct packed {
    logic active;
    logic push;
    logic fin;
  } mcpg_front_stat_t;

  typedef struct packed {
    logic             busy;
    logic [OCT_W-1:0] octant;
  } mcpg_back_stat_t;

endpackage

[hdl/mcpg_if.sv]
// Channel interfaces: command words in, pixel words out.
interface mcpg_in_if;
  import mcpg_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [IN_W-1:0]   center_x;
  logic [IN_W-1:0]   center_y;
  logic [IN_W-1:0]   radius;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, op, center_x, center_y, radius, red, green, blue,
                  input ready);
  modport sink   (input valid, op, center_x, center_y, radius, red, green, blue,
                  output ready);
endinterface

interface mcpg_out_if;
  import mcpg_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;
  logic [CHAN_W-1:0]       out_red;
  logic [CHAN_W-1:0]       out_green;
  logic [CHAN_W-1:0]       out_blue;
  logic                    last;
  logic                    done_res;

  modport source (output valid, pixel_x, pixel_y, out_red, out_green, out_blue, last,
                  done_res, input ready);
  modport sink   (input valid, pixel_x, pixel_y, out_red, out_green, out_blue, last,
                  done_res, output ready);
endinterface

[hdl/midpoint_circle_pixel_generator.sv]
// Top level of the midpoint circle pixel generator.
//
// in_if takes command words. A start word (op = 0) loads center, radius and
// colour and emits nothing. A step word (op = 1) while a circle is running
// queues one job; each job comes out on out_if as eight pixel words in octant
// order, one per cycle while out_if is ready, last set on the eighth,
// done_res set on all eight of the step that closes the circle. A step word
// with no circle running is dropped. Pixel coordinates are signed 14-bit and
// unclipped. The first pixel of a step passes through the queue, the job
// register and the output register. The back end drives one pixel word per
// cycle into it while out_if is ready; step words queue up during a job.
// A two-entry job queue sits between the front and back ends.
// Reset: no circle running, queue and output register empty.
// When out_if stalls, the output register holds its word, the back end halts,
// the queue fills and in_if.ready drops once it holds two jobs.
module midpoint_circle_pixel_generator import mcpg_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  mcpg_in_if.sink    in_if,
  mcpg_out_if.source out_if
);

  localparam int OW = COORD_BITS + 1;
  localparam int JW = 2 * COORD_BITS + COLOUR_W + 2 * OW + 1;

  logic               q_push, q_ready, q_pop, q_valid;
  logic [JW-1:0]      q_wdata, q_rdata;
  logic [Q_CNT_W-1:0] q_level;
  mcpg_front_stat_t   fr_stat;
  mcpg_back_stat_t    bk_stat;

  mcpg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .stat    (fr_stat)
  );

  mcpg_queue #(.W(JW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_wdata),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_rdata),
    .level      (q_level)
  );

  mcpg_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_if  (out_if),
    .stat    (bk_stat)
  );

  a_q_level: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= Q_CNT_W'(2))
    else $error("job queue overfilled");

  a_last_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.last |-> bk_stat.octant == '0)
    else $error("octant counter out of step with last pixel");

  a_idle_on_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(fr_stat.active) |-> $past(fr_stat.push && fr_stat.fin))
    else $error("circle ended without a final step");

  a_busy_when_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> $past(bk_stat.busy))
    else $error("pixel word without a job");

endmodule

[hdl/mcpg_front.sv]
// Front end: takes command words, holds circle state, queues one job per step.
module mcpg_front import mcpg_pkg::*; #(
  parameter int COORD_BITS = 12,
  localparam int OW = COORD_BITS + 1,
  localparam int EW = COORD_BITS + 3,
  localparam int JW = 2 * COORD_BITS + COLOUR_W + 2 * OW + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  mcpg_in_if.sink          in_if,
  input  logic             q_ready,
  output logic             q_push,
  output logic [JW-1:0]    q_data,
  output mcpg_front_stat_t stat
);

  logic                   active_r;
  logic [COORD_BITS-1:0]  ox_r, oy_r;
  logic [COLOUR_W-1:0]    colour_r;
  logic signed [OW-1:0]   x_r, y_r;
  logic signed [EW-1:0]   e_r;

  logic                   accept, is_start;
  logic [COORD_BITS+IN_W-1:0] cx_ext, cy_ext, r_ext;
  logic signed [EW-1:0]   xe, ye, e1, e_nxt;
  logic signed [OW-1:0]   y_nxt, x_nxt;
  logic                   e_le0, e1_gt0, fin;

  assign in_if.ready = q_ready;
  assign accept      = in_if.valid && in_if.ready;
  assign is_start    = mcpg_op_t'(in_if.op) == OP_START;
  assign q_push      = accept && !is_start && active_r;

  // inputs taken modulo 2^COORD_BITS
  assign cx_ext = {{COORD_BITS{1'b0}}, in_if.center_x};
  assign cy_ext = {{COORD_BITS{1'b0}}, in_if.center_y};
  assign r_ext  = {{COORD_BITS{1'b0}}, in_if.radius};

  // midpoint update: bump y if e <= 0, then pull x in if the new e > 0
  always_comb begin
    xe     = {{(EW-OW){x_r[OW-1]}}, x_r};
    ye     = {{(EW-OW){y_r[OW-1]}}, y_r};
    e_le0  = e_r[EW-1] || (e_r == '0);
    y_nxt  = e_le0 ? y_r + OW'(1) : y_r;
    e1     = e_le0 ? e_r + (ye <<< 1) + EW'(3) : e_r;
    e1_gt0 = !e1[EW-1] && (e1 != '0);
    x_nxt  = e1_gt0 ? x_r - OW'(1) : x_r;
    e_nxt  = e1_gt0 ? e1 - ((xe <<< 1) - EW'(1)) : e1;
    fin    = x_nxt < y_nxt;
  end

  assign q_data = {ox_r, oy_r, colour_r, x_r, y_r, fin};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (accept && is_start) begin
      active_r <= 1'b1;
    end else if (q_push && fin) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_start) begin
      ox_r     <= cx_ext[COORD_BITS-1:0];
      oy_r     <= cy_ext[COORD_BITS-1:0];
      x_r      <= {1'b0, r_ext[COORD_BITS-1:0]};
      y_r      <= '0;
      e_r      <= '0;
      colour_r <= {in_if.red, in_if.green, in_if.blue};
    end else if (q_push) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      e_r <= e_nxt;
    end
  end

  assign stat = '{active: active_r, push: q_push, fin: fin};

endmodule

[hdl/mcpg_queue.sv]
// Two-entry job queue between front and back end.
module mcpg_queue import mcpg_pkg::*; #(
  parameter int W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [W-1:0]       push_data,
  output logic               push_ready,
  input  logic               pop,
  output logic               pop_valid,
  output logic [W-1:0]       pop_data,
  output logic [Q_CNT_W-1:0] level
);

  logic [W-1:0]       mem_r [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign push_ready = cnt_r != Q_CNT_W'(2);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign level      = cnt_r;
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + Q_CNT_W'(1);
    else if (!do_push && do_pop) cnt_nxt = cnt_r - Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

[hdl/mcpg_back.sv]
// Back end: expands one queued job into eight octant pixel words.
module mcpg_back import mcpg_pkg::*; #(
  parameter int COORD_BITS = 12,
  localparam int OW = COORD_BITS + 1,
  localparam int JW = 2 * COORD_BITS + COLOUR_W + 2 * OW + 1,
  localparam int SW = (COORD_BITS + 2 > PIX_W) ? COORD_BITS + 2 : PIX_W
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  logic [JW-1:0]   q_data,
  output logic            q_pop,
  mcpg_out_if.source      out_if,
  output mcpg_back_stat_t stat
);

  localparam int FIN_B = 0;
  localparam int Y_LO  = 1;
  localparam int X_LO  = Y_LO + OW;
  localparam int C_LO  = X_LO + OW;
  localparam int OY_LO = C_LO + COLOUR_W;
  localparam int OX_LO = OY_LO + COORD_BITS;

  logic [JW-1:0]           job_r;
  logic                    job_vld_r;
  logic [OCT_W-1:0]        k_r;
  logic                    out_vld_r;
  logic signed [PIX_W-1:0] px_r, py_r, px_nxt, py_nxt;
  logic [COLOUR_W-1:0]     colour_r;
  logic                    last_r, done_r;

  logic                    adv, k_end;
  logic signed [OW-1:0]    jx, jy, a, b;
  logic signed [SW-1:0]    ae, be, ox_e, oy_e, sx, sy;
  logic                    swap, neg_x, neg_y;

  assign jx    = job_r[X_LO +: OW];
  assign jy    = job_r[Y_LO +: OW];
  assign k_end = &k_r;
  assign adv   = job_vld_r && (!out_vld_r || out_if.ready);
  assign q_pop = q_valid && (!job_vld_r || (adv && k_end));

  // octant k: swap x/y on 1,2,5,6; negate column on 2..5; negate row on 4..7
  always_comb begin
    swap  = k_r[1] ^ k_r[0];
    neg_x = k_r[2] ^ k_r[1];
    neg_y = k_r[2];
    a     = swap ? jy : jx;
    b     = swap ? jx : jy;
    ae    = {{(SW-OW){a[OW-1]}}, a};
    be    = {{(SW-OW){b[OW-1]}}, b};
    ox_e  = {{(SW-COORD_BITS){1'b0}}, job_r[OX_LO +: COORD_BITS]};
    oy_e  = {{(SW-COORD_BITS){1'b0}}, job_r[OY_LO +: COORD_BITS]};
    sx    = ox_e + (neg_x ? -ae : ae);
    sy    = oy_e + (neg_y ? -be : be);
    px_nxt = sx[PIX_W-1:0];
    py_nxt = sy[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
      k_r       <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (q_pop) job_vld_r <= 1'b1;
      else if (adv && k_end) job_vld_r <= 1'b0;
      if (adv) k_r <= k_r + OCT_W'(1);
      if (adv) out_vld_r <= 1'b1;
      else if (out_if.ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_data;
    if (adv) begin
      px_r     <= px_nxt;
      py_r     <= py_nxt;
      colour_r <= job_r[C_LO +: COLOUR_W];
      last_r   <= k_end;
      done_r   <= job_r[FIN_B];
    end
  end

  assign out_if.valid     = out_vld_r;
  assign out_if.pixel_x   = px_r;
  assign out_if.pixel_y   = py_r;
  assign out_if.out_red   = colour_r[2*CHAN_W +: CHAN_W];
  assign out_if.out_green = colour_r[CHAN_W +: CHAN_W];
  assign out_if.out_blue  = colour_r[0 +: CHAN_W];
  assign out_if.last      = last_r;
  assign out_if.done_res  = done_r;

  assign stat = '{busy: job_vld_r, octant: k_r};

endmodule
